FILE: rtl/wcpb_pkg.sv
// Package for the weighted column profile builder.
// Holds the request and response payload types, the action codes, the sequencer states
// and the fixed-point constants. It has no dependencies.
`default_nettype none

package wcpb_pkg;

	localparam int unsigned ENTRY_W = 17;
	localparam logic [ENTRY_W-1:0] ONE_Q16 = 17'h10000;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ACCUM = 2'd1,
		ACT_BLEND = 2'd2,
		ACT_READ  = 2'd3
	} wcpb_action_t;

	typedef struct packed {
		wcpb_action_t       action;
		logic [9:0]         column;
		logic [4:0]         residue_code;
		logic [ENTRY_W-1:0] weight;
	} wcpb_req_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] entry_value;
		logic               overflow_seen;
	} wcpb_rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCALE,
		ST_DRAIN,
		ST_ACC_RD,
		ST_ACC_WR,
		ST_RD_RD,
		ST_RESP
	} wcpb_state_t;

endpackage

`default_nettype wire

FILE: rtl/wcpb_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// Stand-alone; it does not use the package.
`default_nettype none

module wcpb_ram #(
	parameter int unsigned WIDTH = 17,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: rtl/weighted_column_profile_builder_top.sv
// Weighted column profile builder: one Q1.16 entry per residue per column in one RAM; uses
// wcpb_pkg and wcpb_ram. One request at a time; a read loads the response register, and a blend
// scales each entry of the column, one multiplier scaling an entry per cycle, then accumulates
// if the residue is valid. Out-of-range reads answer zero; other requests with an out-of-range
// column, or accumulates with an out-of-range residue, are dropped. A read waits on a held
// response. Reset clears the sequencer, response valid and overflow flag, not the profile RAM.
`default_nettype none

module weighted_column_profile_builder_top #(
	parameter int unsigned ALPHABET_SIZE = 32,
	parameter int unsigned MAX_COLUMNS   = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  wcpb_pkg::wcpb_req_t req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output wcpb_pkg::wcpb_rsp_t rsp
);

	import wcpb_pkg::*;

	localparam int unsigned RES_W   = $clog2(ALPHABET_SIZE);
	localparam int unsigned COL_NUM = (MAX_COLUMNS < 1024) ? MAX_COLUMNS : 1024;
	localparam int unsigned COL_W   = $clog2(COL_NUM);
	localparam int unsigned ADDR_W  = COL_W + RES_W;
	localparam int unsigned DEPTH   = 1 << ADDR_W;
	localparam logic [RES_W-1:0] LAST_IDX = RES_W'(ALPHABET_SIZE - 1);

	wcpb_state_t state_q, state_d;

	logic [COL_W-1:0]   col_q;
	logic [RES_W-1:0]   res_q;
	logic [ENTRY_W-1:0] w_q;
	logic               col_ok_q;
	logic               res_ok_q;
	logic [RES_W-1:0]   idx_q;
	logic               ovf_q;
	logic               rsp_valid_q;
	wcpb_rsp_t          rsp_q;

	logic               valid_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic               valid_s2;
	logic [ADDR_W-1:0]  addr_s2;
	logic [ENTRY_W-1:0] prod_s2;

	logic               col_ok;
	logic               res_ok;
	logic [ENTRY_W-1:0] w_sat;
	logic               accept;
	logic [ENTRY_W-1:0] keep;
	logic [2*ENTRY_W-1:0] prod;
	logic [ENTRY_W:0]   sum;
	logic               sum_over;
	logic [ENTRY_W-1:0] sum_sat;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	logic               idx_clr;
	logic               idx_inc;
	logic               ovf_set;
	logic               rsp_load;
	logic               scale_rd;

	assign col_ok   = 32'(req.column) < 32'(MAX_COLUMNS);
	assign res_ok   = 32'(req.residue_code) < 32'(ALPHABET_SIZE);
	assign w_sat    = (req.weight > ONE_Q16) ? ONE_Q16 : req.weight;
	assign accept   = req_valid && req_ready;
	assign keep     = ONE_Q16 - w_q;
	assign prod     = (2*ENTRY_W)'(ram_rdata) * (2*ENTRY_W)'(keep);
	assign sum      = {1'b0, ram_rdata} + {1'b0, w_q};
	assign sum_over = sum > {1'b0, ONE_Q16};
	assign sum_sat  = sum_over ? ONE_Q16 : sum[ENTRY_W-1:0];

	wcpb_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = addr_s2;
		ram_wdata = prod_s2;
		ram_re    = 1'b0;
		ram_raddr = {col_q, idx_q};
		idx_clr   = 1'b0;
		idx_inc   = 1'b0;
		ovf_set   = 1'b0;
		rsp_load  = 1'b0;
		scale_rd  = 1'b0;
		if (valid_s2) begin
			ram_we = 1'b1;
		end
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					idx_clr = 1'b1;
					case (req.action)
						ACT_CLEAR: state_d = col_ok ? ST_CLEAR : ST_IDLE;
						ACT_ACCUM: state_d = (col_ok && res_ok) ? ST_ACC_RD : ST_IDLE;
						ACT_BLEND: state_d = col_ok ? ST_SCALE : ST_IDLE;
						ACT_READ:  state_d = (col_ok && res_ok) ? ST_RD_RD : ST_RESP;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = {col_q, idx_q};
				ram_wdata = '0;
				idx_inc   = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCALE: begin
				ram_re   = 1'b1;
				scale_rd = 1'b1;
				idx_inc  = 1'b1;
				if (idx_q == LAST_IDX) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!valid_s1 && !valid_s2) begin
					state_d = res_ok_q ? ST_ACC_RD : ST_IDLE;
				end
			end
			ST_ACC_RD: begin
				ram_re    = 1'b1;
				ram_raddr = {col_q, res_q};
				state_d   = ST_ACC_WR;
			end
			ST_ACC_WR: begin
				ram_we    = 1'b1;
				ram_waddr = {col_q, res_q};
				ram_wdata = sum_sat;
				ovf_set   = sum_over;
				state_d   = ST_IDLE;
			end
			ST_RD_RD: begin
				ram_re    = 1'b1;
				ram_raddr = {col_q, res_q};
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				if (!rsp_valid_q || rsp_ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (idx_clr) begin
				idx_q <= '0;
			end else if (idx_inc) begin
				idx_q <= idx_q + 1'b1;
			end
			if (ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			valid_s1 <= scale_rd;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q    <= req.column[COL_W-1:0];
			res_q    <= RES_W'(req.residue_code);
			w_q      <= w_sat;
			col_ok_q <= col_ok;
			res_ok_q <= res_ok;
		end
		addr_s1 <= ram_raddr;
		addr_s2 <= addr_s1;
		prod_s2 <= prod[ENTRY_W+15:16];
		if (rsp_load) begin
			rsp_q.entry_value   <= (col_ok_q && res_ok_q) ? ram_rdata : '0;
			rsp_q.overflow_seen <= ovf_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

FILE: tb/weighted_column_profile_builder_top_tb.sv
// Testbench for weighted_column_profile_builder_top, depending on wcpb_pkg for payload types.
// Directed and random requests are checked against a behavioral profile model kept here,
// under several idle and stall mixes on both handshakes.
`default_nettype none

module weighted_column_profile_builder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wcpb_pkg::*;

	localparam int NUM_COLUMNS  = 1024;
	localparam int NUM_RESIDUES = 32;
	localparam int CYCLE_LIMIT  = 600000;
	localparam int SETTLE_CYCLES = 64;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      req_valid;
	logic      req_ready;
	wcpb_req_t req;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	wcpb_rsp_t rsp;

	logic [ENTRY_W-1:0] profile_model [NUM_COLUMNS][NUM_RESIDUES];
	logic               overflow_model = 1'b0;
	bit                 col_cleared [NUM_COLUMNS];
	int                 cleared_list [$];
	wcpb_rsp_t          pending_reads [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int cycle_count   = 0;
	int error_count   = 0;
	int reads_checked = 0;
	int action_count [4];
	int hot_cols [4];

	weighted_column_profile_builder_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(negedge clk) begin
		rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	function automatic logic [ENTRY_W-1:0] add_saturating(input logic [ENTRY_W-1:0] a,
			input logic [ENTRY_W-1:0] b);
		logic [ENTRY_W:0] total;
		total = {1'b0, a} + {1'b0, b};
		if (total > {1'b0, ONE_Q16}) begin
			overflow_model = 1'b1;
			total = {1'b0, ONE_Q16};
		end
		return total[ENTRY_W-1:0];
	endfunction

	function automatic bit apply_to_profile(input wcpb_req_t item, output wcpb_rsp_t answer);
		logic [ENTRY_W-1:0] w;
		logic [ENTRY_W-1:0] keep;
		logic [33:0]        scaled;
		int                 c;
		int                 r;
		c = item.column;
		r = item.residue_code;
		w = (item.weight > ONE_Q16) ? ONE_Q16 : item.weight;
		answer = '0;
		action_count[item.action]++;
		case (item.action)
			ACT_CLEAR: begin
				for (int i = 0; i < NUM_RESIDUES; i++)
					profile_model[c][i] = '0;
				if (!col_cleared[c]) begin
					col_cleared[c] = 1'b1;
					cleared_list.push_back(c);
				end
				return 1'b0;
			end
			ACT_ACCUM: begin
				profile_model[c][r] = add_saturating(profile_model[c][r], w);
				return 1'b0;
			end
			ACT_BLEND: begin
				keep = ONE_Q16 - w;
				for (int i = 0; i < NUM_RESIDUES; i++) begin
					scaled = profile_model[c][i] * keep;
					profile_model[c][i] = scaled[32:16];
				end
				profile_model[c][r] = add_saturating(profile_model[c][r], w);
				return 1'b0;
			end
			default: begin
				answer.entry_value = profile_model[c][r];
				answer.overflow_seen = overflow_model;
				return 1'b1;
			end
		endcase
	endfunction

	always @(posedge clk) begin
		wcpb_rsp_t exp_rsp;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected response, expected none, actual entry %0d overflow %0b",
					$time, rsp.entry_value, rsp.overflow_seen);
				error_count++;
			end else begin
				exp_rsp = pending_reads.pop_front();
				reads_checked++;
				if (rsp.entry_value !== exp_rsp.entry_value) begin
					$display("%0t: entry_value mismatch, expected %0d, actual %0d",
						$time, exp_rsp.entry_value, rsp.entry_value);
					error_count++;
				end
				if (rsp.overflow_seen !== exp_rsp.overflow_seen) begin
					$display("%0t: overflow_seen mismatch, expected %0b, actual %0b",
						$time, exp_rsp.overflow_seen, rsp.overflow_seen);
					error_count++;
				end
			end
		end
	end

	task automatic send_request(input wcpb_req_t item);
		wcpb_rsp_t answer;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		if (apply_to_profile(item, answer))
			pending_reads.push_back(answer);
		@(negedge clk);
	endtask

	task automatic issue(input wcpb_action_t act, input int col, input int res, input int w);
		wcpb_req_t item;
		item.action = act;
		item.column = 10'(col);
		item.residue_code = 5'(res);
		item.weight = 17'(w);
		send_request(item);
	endtask

	task automatic drain_responses();
		req_valid <= 1'b0;
		@(negedge clk);
		while (pending_reads.size() != 0)
			@(negedge clk);
	endtask

	task automatic test_clear_and_read_extremes();
		issue(ACT_CLEAR, 0, 0, 0);
		issue(ACT_CLEAR, 1023, 31, 'h1FFFF);
		issue(ACT_CLEAR, 341, 21, 'h0AAAA);
		issue(ACT_CLEAR, 682, 10, 'h15555);
		issue(ACT_READ, 0, 0, 0);
		issue(ACT_READ, 1023, 31, 'h1FFFF);
	endtask

	task automatic test_accumulate();
		issue(ACT_ACCUM, 0, 0, 1);
		issue(ACT_ACCUM, 1023, 31, 'h0FFFF);
		issue(ACT_ACCUM, 341, 21, 'h1FFFF);
		issue(ACT_READ, 341, 21, 0);
		issue(ACT_READ, 1023, 31, 0);
	endtask

	task automatic test_blend();
		issue(ACT_BLEND, 0, 5, 'h08000);
		issue(ACT_READ, 0, 5, 0);
		issue(ACT_READ, 0, 0, 0);
		issue(ACT_BLEND, 1023, 31, 0);
		issue(ACT_BLEND, 682, 10, 'h10000);
		issue(ACT_READ, 682, 10, 0);
	endtask

	task automatic test_saturation();
		issue(ACT_ACCUM, 341, 21, 1);
		issue(ACT_READ, 341, 21, 0);
		issue(ACT_BLEND, 1023, 31, 'h1FFFF);
		issue(ACT_READ, 1023, 31, 0);
	endtask

	task automatic test_random(input int idle_pct, input int stall, input int count);
		int roll;
		int col;
		int w;
		wcpb_action_t act;
		send_idle_pct = idle_pct;
		stall_pct = stall;
		for (int i = 0; i < 4; i++) begin
			hot_cols[i] = $urandom_range(0, NUM_COLUMNS - 1);
			issue(ACT_CLEAR, hot_cols[i], $urandom_range(0, 31), $urandom_range(0, 'h1FFFF));
		end
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 8) begin
				act = ACT_CLEAR;
				col = ($urandom_range(0, 3) == 0) ? $urandom_range(0, NUM_COLUMNS - 1)
					: hot_cols[$urandom_range(0, 3)];
			end else begin
				act = (roll < 40) ? ACT_ACCUM : (roll < 62) ? ACT_BLEND : ACT_READ;
				col = ($urandom_range(0, 4) == 0)
					? cleared_list[$urandom_range(0, cleared_list.size() - 1)]
					: hot_cols[$urandom_range(0, 3)];
			end
			roll = $urandom_range(0, 99);
			if (roll < 10)
				w = 0;
			else if (roll < 18)
				w = 'h10000;
			else if (roll < 28)
				w = $urandom_range('h10001, 'h1FFFF);
			else if (roll < 60)
				w = $urandom_range(0, 'h0FFF);
			else
				w = $urandom_range(0, 'h1FFFF);
			issue(act, col, $urandom_range(0, NUM_RESIDUES - 1), w);
			if (n % 64 == 63 && $urandom_range(0, 1) == 1)
				drain_responses();
		end
		drain_responses();
	endtask

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_clear_and_read_extremes();
		test_accumulate();
		test_blend();
		test_saturation();
		drain_responses();
		test_random(0, 0, 200);
		test_random(61, 0, 200);
		test_random(0, 61, 200);
		test_random(17, 17, 200);
		send_idle_pct = 0;
		stall_pct = 0;
		drain_responses();
		repeat (SETTLE_CYCLES) @(negedge clk);
		error_count += pending_reads.size();
		$display("Ran %0d clears, %0d accumulates, %0d blends and %0d reads over %0d columns,",
			action_count[ACT_CLEAR], action_count[ACT_ACCUM], action_count[ACT_BLEND],
			action_count[ACT_READ], cleared_list.size());
		$display("with four idle and stall mixes; %0d responses checked, %0d errors.",
			reads_checked, error_count);
		if (error_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

`default_nettype wire
